@@ design/pfc_pkg.sv @@
// Shared constants and controller/datapath interface types for the prefix-free code checker.
package pfc_pkg;

  localparam int MAX_NODES     = 4096;
  localparam int ALPHABET_SIZE = 10;

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int COUNT_W    = NODE_W + 1;
  localparam int SLOT_DEPTH = MAX_NODES * ALPHABET_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);
  localparam int DIGIT_W    = 4;
  localparam int SYM_W      = $clog2(ALPHABET_SIZE);
  localparam int ROW_W      = ALPHABET_SIZE + 1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;      // latch digit item, read node row and child slot
    logic new_list;     // empty the trie and clear all flags
    logic fail;         // mark number and list failed
    logic overflow;     // mark pool exhausted
    logic follow;       // walk to existing child, read its row
    logic alloc;        // link a fresh node under the current one
    logic write_fresh;  // initialise the fresh node's row
    logic set_end;      // mark a number ending on the current node
    logic emit;         // load result register, rewind walk
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic list_failed;
    logic last;
    logic bad;          // illegal digit or stored number on the path
    logic hit;          // child slot already present
    logic pool_full;
    logic has_child;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/pfc_datapath.sv @@
// Datapath: node pool memories, trie walk registers, list flags and result register.
module pfc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfc_pkg::dp_cmd_t            cmd_i,
  output pfc_pkg::dp_status_t         status_o,
  input  logic [pfc_pkg::DIGIT_W-1:0] digit_i,
  input  logic                        last_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic                        number_ok_o,
  output logic                        list_consistent_o,
  output logic                        table_full_o
);

  // Row word: {number ends here, child present bits}
  logic [pfc_pkg::ROW_W-1:0]  row_mem   [pfc_pkg::MAX_NODES];
  logic [pfc_pkg::NODE_W-1:0] child_mem [pfc_pkg::SLOT_DEPTH];

  logic [pfc_pkg::ROW_W-1:0]   row_rd_q;
  logic [pfc_pkg::NODE_W-1:0]  child_rd_q;
  logic [pfc_pkg::DIGIT_W-1:0] digit_q;
  logic                        last_q;
  logic [pfc_pkg::SLOT_W-1:0]  slot_q;
  logic [pfc_pkg::SLOT_W-1:0]  slot_d;

  logic [pfc_pkg::NODE_W-1:0]        walk_q;
  logic [pfc_pkg::COUNT_W-1:0]       next_free_q;
  logic                              number_failed_q;
  logic                              list_failed_q;
  logic                              overflow_q;
  logic [pfc_pkg::ALPHABET_SIZE-1:0] root_present_q;
  logic                              root_ends_q;

  logic out_valid_q;
  logic out_ok_q;
  logic out_cons_q;
  logic out_full_q;

  logic [pfc_pkg::ROW_W-1:0]         row_cur;
  logic [pfc_pkg::ALPHABET_SIZE-1:0] cur_present;
  logic                              cur_ends;
  logic [pfc_pkg::SYM_W-1:0]         sym;
  logic [pfc_pkg::ALPHABET_SIZE-1:0] sym_bit;
  logic                              at_root;
  logic                              digit_bad;
  logic [pfc_pkg::NODE_W-1:0]        fresh;

  logic                        row_we;
  logic                        row_re;
  logic [pfc_pkg::NODE_W-1:0]  row_wa;
  logic [pfc_pkg::NODE_W-1:0]  row_ra;
  logic [pfc_pkg::ROW_W-1:0]   row_wd;

  // Root row lives in flops so a new list empties the trie at once
  assign at_root     = (walk_q == '0);
  assign row_cur     = at_root ? {root_ends_q, root_present_q} : row_rd_q;
  assign cur_ends    = row_cur[pfc_pkg::ALPHABET_SIZE];
  assign cur_present = row_cur[pfc_pkg::ALPHABET_SIZE-1:0];
  assign sym         = pfc_pkg::SYM_W'(digit_q);
  assign sym_bit     = pfc_pkg::ALPHABET_SIZE'(1) << sym;
  assign digit_bad   = (int'(digit_q) >= pfc_pkg::ALPHABET_SIZE);
  assign fresh       = next_free_q[pfc_pkg::NODE_W-1:0];
  assign slot_d      = pfc_pkg::SLOT_W'(int'(walk_q) * pfc_pkg::ALPHABET_SIZE + int'(digit_i));

  assign status_o.list_failed = list_failed_q;
  assign status_o.last        = last_q;
  assign status_o.bad         = digit_bad || cur_ends;
  assign status_o.hit         = digit_bad ? 1'b0 : cur_present[sym];
  assign status_o.pool_full   = (next_free_q >= pfc_pkg::COUNT_W'(pfc_pkg::MAX_NODES));
  assign status_o.has_child   = |cur_present;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  assign row_re = cmd_i.capture || cmd_i.follow;
  assign row_ra = cmd_i.follow ? child_rd_q : walk_q;
  assign row_wa = walk_q;

  always_comb begin
    row_we = 1'b0;
    row_wd = row_cur;
    if (cmd_i.alloc) begin
      row_we = !at_root;
      row_wd = {1'b0, cur_present | sym_bit};
    end else if (cmd_i.write_fresh) begin
      row_we = 1'b1;
      row_wd = {last_q, {pfc_pkg::ALPHABET_SIZE{1'b0}}};
    end else if (cmd_i.set_end) begin
      row_we = !at_root;
      row_wd = {1'b1, cur_present};
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    if (row_re) row_rd_q <= row_mem[row_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) child_mem[slot_q] <= fresh;
    if (cmd_i.capture) child_rd_q <= child_mem[slot_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      digit_q <= digit_i;
      last_q  <= last_i;
      slot_q  <= slot_d;
    end
    if (cmd_i.emit) begin
      out_ok_q   <= !number_failed_q;
      out_cons_q <= !list_failed_q;
      out_full_q <= overflow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q          <= '0;
      next_free_q     <= pfc_pkg::COUNT_W'(1);
      number_failed_q <= 1'b0;
      list_failed_q   <= 1'b0;
      overflow_q      <= 1'b0;
      root_present_q  <= '0;
      root_ends_q     <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cmd_i.new_list) begin
        walk_q          <= '0;
        next_free_q     <= pfc_pkg::COUNT_W'(1);
        number_failed_q <= 1'b0;
        list_failed_q   <= 1'b0;
        overflow_q      <= 1'b0;
        root_present_q  <= '0;
        root_ends_q     <= 1'b0;
      end
      if (cmd_i.fail) begin
        number_failed_q <= 1'b1;
        list_failed_q   <= 1'b1;
      end
      if (cmd_i.overflow) overflow_q <= 1'b1;
      if (cmd_i.follow) walk_q <= child_rd_q;
      if (cmd_i.alloc) begin
        walk_q      <= fresh;
        next_free_q <= next_free_q + pfc_pkg::COUNT_W'(1);
        if (at_root) root_present_q <= root_present_q | sym_bit;
      end
      if (cmd_i.set_end && at_root) root_ends_q <= 1'b1;
      if (cmd_i.emit) begin
        walk_q          <= '0;
        number_failed_q <= 1'b0;
        out_valid_q     <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign number_ok_o       = out_ok_q;
  assign list_consistent_o = out_cons_q;
  assign table_full_o      = out_full_q;

  // The walk only ever sits on an allocated node
  a_walk_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_q < next_free_q[pfc_pkg::NODE_W-1:0] || next_free_q[pfc_pkg::NODE_W])
    else $error("walk on unallocated node");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= pfc_pkg::COUNT_W'(pfc_pkg::MAX_NODES))
    else $error("free node counter past pool size");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc |-> !status_o.pool_full)
    else $error("allocation with pool exhausted");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> status_o.out_free)
    else $error("result loaded over pending transaction");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_failed_q && !cmd_i.new_list |=> list_failed_q)
    else $error("list failure cleared without new list");

endmodule

@@ design/pfc_ctrl.sv @@
// Controller state machine sequencing lookup, allocation, end check and result.
module pfc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                command_i,
  input  logic                last_i,
  output logic                in_stall_o,
  output pfc_pkg::dp_cmd_t    cmd_o,
  input  pfc_pkg::dp_status_t status_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (command_i) begin
            cmd_o.new_list = 1'b1;
          end else if (status_i.list_failed) begin
            cmd_o.fail = 1'b1;
            if (last_i) state_d = S_EMIT;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (status_i.bad) begin
          cmd_o.fail = 1'b1;
          state_d    = status_i.last ? S_EMIT : S_IDLE;
        end else if (status_i.hit) begin
          cmd_o.follow = 1'b1;
          state_d      = status_i.last ? S_FINAL : S_IDLE;
        end else if (status_i.pool_full) begin
          cmd_o.fail     = 1'b1;
          cmd_o.overflow = 1'b1;
          state_d        = status_i.last ? S_EMIT : S_IDLE;
        end else begin
          cmd_o.alloc = 1'b1;
          state_d     = S_ALLOC;
        end
      end
      S_ALLOC: begin
        // a fresh node has no children, so a number ending here always passes
        cmd_o.write_fresh = 1'b1;
        state_d           = status_i.last ? S_EMIT : S_IDLE;
      end
      S_FINAL: begin
        if (status_i.has_child) cmd_o.fail = 1'b1;
        else                    cmd_o.set_end = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

@@ design/prefix_free_code_checker.sv @@
// Top level: a digit is accepted, then looked up in the row and child memories, with an extra
// allocation step if a node is allocated; once the list has failed the digit is only marked failed.
// A last digit on an existing path adds an end check, and every last digit adds a step that
// loads the result register, waiting while an earlier result is still stalled.
// Reset clears the controller, root node, free-node counter and flags; no clearing pass.
module prefix_free_code_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [pfc_pkg::DIGIT_W-1:0] digit_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        number_ok_o,
  output logic                        list_consistent_o,
  output logic                        table_full_o
);

  pfc_pkg::dp_cmd_t    cmd;
  pfc_pkg::dp_status_t status;

  pfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  pfc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .digit_i           (digit_i),
    .last_i            (last_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .number_ok_o       (number_ok_o),
    .list_consistent_o (list_consistent_o),
    .table_full_o      (table_full_o)
  );

endmodule
